// File: hdl/utc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types and constants of the unicode transcoder.
// ----------------------------------------------------------------------------
package utc_pkg;

  localparam int PointW     = 21;
  localparam int CfgIdxW    = 2;
  localparam int QueueDepth = 4;

  localparam logic [CfgIdxW-1:0] CfgEncoding  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDirection = 2'd1;

  localparam logic [PointW-1:0] MaxPoint   = 21'h10FFFF;
  localparam logic [PointW-1:0] PlaneBase  = 21'h010000;
  localparam logic [PointW-1:0] MaxAscii   = 21'h00007F;
  localparam logic [PointW-1:0] MaxTwoByte = 21'h0007FF;
  localparam logic [PointW-1:0] MaxBmp     = 21'h00FFFF;

  localparam logic [15:0] HighSurrogate = 16'hD800;
  localparam logic [15:0] LowSurrogate  = 16'hDC00;
  localparam logic [15:0] SurrogateMask = 16'hFC00;

  localparam logic [7:0] Lead2     = 8'hC0;
  localparam logic [7:0] Lead3     = 8'hE0;
  localparam logic [7:0] Lead4     = 8'hF0;
  localparam logic [7:0] ContByte  = 8'h80;

  // one queued job: a single result, or a run of encoded units
  typedef struct packed {
    logic [PointW-1:0] value;
    logic              error;
    logic [1:0]        span;   // units after the first
    logic              wide;   // utf-16 units
  } job_t;

endpackage

`default_nettype wire

// File: hdl/utc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_in_if
// Input channel: one code unit or code point per beat.
// ----------------------------------------------------------------------------
interface utc_in_if;
  logic                      valid;
  logic                      ready;
  logic [utc_pkg::PointW-1:0] unit_value;

  modport source (output valid, output unit_value, input ready);
  modport sink (input valid, input unit_value, output ready);
endinterface

`default_nettype wire

// File: hdl/utc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_out_if
// Result channel: one code point or code unit per beat.
// ----------------------------------------------------------------------------
interface utc_out_if;
  logic                      valid;
  logic                      ready;
  logic [utc_pkg::PointW-1:0] out_value;
  logic                      last;
  logic                      error;

  modport source (output valid, output out_value, output last, output error, input ready);
  modport sink (input valid, input out_value, input last, input error, output ready);
endinterface

`default_nettype wire

// File: hdl/utc_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface utc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [utc_pkg::CfgIdxW-1:0] index;
  logic                        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/utc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_front
// Accepts code units or code points, runs the decode state and classifies
// each beat that ends a code point into a job for the back end.
// ----------------------------------------------------------------------------
module utc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  utc_in_if.sink            feed,
  utc_cfg_if.sink           cfg,
  input  wire logic         full,
  output logic              push,
  output utc_pkg::job_t     job
);

  logic                       encoding;
  logic                       direction;
  logic [1:0]                 pending;
  logic [utc_pkg::PointW-1:0] partial;
  logic [1:0]                 pending_next;
  logic [utc_pkg::PointW-1:0] partial_next;
  logic [utc_pkg::PointW-1:0] cand;
  logic [utc_pkg::PointW-1:0] cp;
  logic [7:0]                 b;
  logic [15:0]                w;
  logic                       emit;
  logic                       take;
  logic                       cfg_write;

  assign cfg.ready  = 1'b1;
  assign feed.ready = !full;
  assign take       = feed.valid && feed.ready;
  assign cfg_write  = cfg.valid && cfg.ready &&
                      (cfg.index == utc_pkg::CfgEncoding || cfg.index == utc_pkg::CfgDirection);
  assign push       = take && emit;

  always_comb begin
    cp           = feed.unit_value;
    b            = feed.unit_value[7:0];
    w            = feed.unit_value[15:0];
    pending_next = pending;
    partial_next = partial;
    cand         = '0;
    emit         = 1'b0;
    job          = '0;
    if (!direction) begin
      if (!encoding) begin
        if (pending == 2'd0) begin
          priority if (!b[7]) begin
            emit      = 1'b1;
            job.value = {13'd0, b};
          end else if (b[7:5] == utc_pkg::Lead2[7:5]) begin
            partial_next = {10'd0, b[4:0], 6'd0};
            pending_next = 2'd1;
          end else if (b[7:4] == utc_pkg::Lead3[7:4]) begin
            partial_next = {5'd0, b[3:0], 12'd0};
            pending_next = 2'd2;
          end else if (b[7:3] == {utc_pkg::Lead4[7:4], 1'b0}) begin
            partial_next = {b[2:0], 18'd0};
            pending_next = 2'd3;
          end else begin
            emit      = 1'b1;
            job.error = 1'b1;
          end
        end else begin
          pending_next = pending - 2'd1;
          unique case (pending)
            2'd2:    cand = partial | {9'd0, b[5:0], 6'd0};
            2'd3:    cand = partial | {3'd0, b[5:0], 12'd0};
            default: cand = partial | {15'd0, b[5:0]};
          endcase
          partial_next = cand;
          if (pending == 2'd1) begin
            emit = 1'b1;
            if (cand > utc_pkg::MaxPoint) begin
              job.error = 1'b1;
            end else begin
              job.value = cand;
            end
          end
        end
      end else begin
        if (pending == 2'd0) begin
          if ((w & utc_pkg::SurrogateMask) == utc_pkg::HighSurrogate) begin
            partial_next = {1'b0, w[9:0], 10'd0};
            pending_next = 2'd1;
          end else begin
            emit      = 1'b1;
            job.value = {5'd0, w};
          end
        end else begin
          pending_next = 2'd0;
          cand         = {1'b0, partial[19:10], w[9:0]} + utc_pkg::PlaneBase;
          partial_next = cand;
          emit         = 1'b1;
          if (cand > utc_pkg::MaxPoint) begin
            job.error = 1'b1;
          end else begin
            job.value = cand;
          end
        end
      end
    end else begin
      emit     = 1'b1;
      job.wide = encoding;
      if (cp > utc_pkg::MaxPoint) begin
        job.error = 1'b1;
      end else if (!encoding) begin
        job.value = cp;
        priority if (cp <= utc_pkg::MaxAscii) begin
          job.span = 2'd0;
        end else if (cp <= utc_pkg::MaxTwoByte) begin
          job.span = 2'd1;
        end else if (cp <= utc_pkg::MaxBmp) begin
          job.span = 2'd2;
        end else begin
          job.span = 2'd3;
        end
      end else begin
        if (cp <= utc_pkg::MaxBmp) begin
          job.value = cp;
        end else begin
          job.value = cp - utc_pkg::PlaneBase;
          job.span  = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding  <= 1'b0;
      direction <= 1'b0;
      pending   <= 2'd0;
      partial   <= '0;
    end else if (cfg_write) begin
      if (cfg.index == utc_pkg::CfgEncoding) begin
        encoding <= cfg.data;
      end else begin
        direction <= cfg.data;
      end
      pending <= 2'd0;
      partial <= '0;
    end else if (take) begin
      pending <= pending_next;
      partial <= partial_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/utc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_queue
// Small job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module utc_queue #(
  parameter int Depth = utc_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire utc_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output utc_pkg::job_t      head_job
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);

  utc_pkg::job_t   mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/utc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_back
// Expands queued jobs into result beats, one unit per cycle while the
// result side does not stall, into the output register.
// ----------------------------------------------------------------------------
module utc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire utc_pkg::job_t head_job,
  output logic               pop,
  utc_out_if.source          result
);

  logic [1:0]                 idx;
  logic [1:0]                 rest;
  logic                       load;
  logic                       out_valid;
  logic [utc_pkg::PointW-1:0] out_value;
  logic                       out_last;
  logic                       out_error;
  logic [utc_pkg::PointW-1:0] unit;
  logic [7:0]                 byte_u;
  logic [15:0]                word_u;

  assign load = head_valid && (!out_valid || result.ready);
  assign pop  = load && (idx == head_job.span);
  assign rest = head_job.span - idx;

  assign result.valid     = out_valid;
  assign result.out_value = out_value;
  assign result.last      = out_last;
  assign result.error     = out_error;

  always_comb begin
    byte_u = '0;
    word_u = '0;
    unit   = head_job.value;
    if (head_job.span != 2'd0) begin
      if (head_job.wide) begin
        if (idx == 2'd0) begin
          word_u = utc_pkg::HighSurrogate | {6'd0, head_job.value[19:10]};
        end else begin
          word_u = utc_pkg::LowSurrogate | {6'd0, head_job.value[9:0]};
        end
        unit = {5'd0, word_u};
      end else begin
        if (idx == 2'd0) begin
          unique case (head_job.span)
            2'd1:    byte_u = utc_pkg::Lead2 | {3'd0, head_job.value[10:6]};
            2'd2:    byte_u = utc_pkg::Lead3 | {4'd0, head_job.value[15:12]};
            default: byte_u = utc_pkg::Lead4 | {5'd0, head_job.value[20:18]};
          endcase
        end else begin
          unique case (rest)
            2'd0:    byte_u = utc_pkg::ContByte | {2'd0, head_job.value[5:0]};
            2'd1:    byte_u = utc_pkg::ContByte | {2'd0, head_job.value[11:6]};
            default: byte_u = utc_pkg::ContByte | {2'd0, head_job.value[17:12]};
          endcase
        end
        unit = {13'd0, byte_u};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= pop ? 2'd0 : idx + 2'd1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= unit;
      out_last  <= (idx == head_job.span);
      out_error <= head_job.error;
    end
  end

endmodule

`default_nettype wire

// File: hdl/unicode_transcoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_transcoder
// Streaming UTF-8 / UTF-16 transcoder with selectable direction.
// ----------------------------------------------------------------------------
// The block takes one beat on feed every cycle while the job queue is not
// full. Decoding gives one result beat per finished code point and none
// for units in the middle of a sequence; encoding gives one to four unit
// beats per code point, last set on the final one. The back end emits one
// result beat per cycle while the result side is ready; the front end
// keeps accepting until the job queue (QueueDepth entries) fills. A job
// passes through the queue before its first result is registered in the
// output register. Invalid lead bytes and code points above 0x10FFFF give
// one beat with value 0 and error set. Configuration writes are meant for
// idle periods only; encoding or direction writes clear any partial sequence.
// ----------------------------------------------------------------------------
module unicode_transcoder #(
  parameter int QueueDepth = utc_pkg::QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  utc_in_if.sink    feed,
  utc_cfg_if.sink   cfg,
  utc_out_if.source result
);

  logic          push;
  logic          pop;
  logic          full;
  logic          head_valid;
  utc_pkg::job_t push_job;
  utc_pkg::job_t head_job;

  utc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .feed (feed),
    .cfg  (cfg),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  utc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  utc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire

// File: sim/utc_checker.sv
// ----------------------------------------------------------------------------
// utc_checker
// Watches the feed, configuration and result channels of the transcoder.
// Keeps its own copy of the mode registers and of the partial sequence,
// works out the beats that each accepted feed beat owes, and compares every
// result beat against the oldest owed one.
// ----------------------------------------------------------------------------
module utc_checker
  import utc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  utc_in_if    feed,
  utc_cfg_if   cfg,
  utc_out_if   result,
  output int   fail_count,
  output int   owed_count,
  output int   units_seen,
  output int   beats_seen,
  output int   errors_seen,
  output int   writes_seen
);

  typedef struct packed {
    logic [PointW-1:0] value;
    logic              last;
    logic              error;
  } unit_beat_t;

  unit_beat_t        owed_q[$];
  logic              utf16;
  logic              encode_dir;
  logic [1:0]        pend;
  logic [PointW-1:0] acc;
  int                fails;
  int                units;
  int                beats;
  int                errs;
  int                writes;

  task automatic owe(input logic [PointW-1:0] v, input logic lst, input logic er);
    owed_q.push_back('{v, lst, er});
  endtask

  task automatic owe_point(input logic [PointW-1:0] cp);
    if (cp > MaxPoint) owe('0, 1'b1, 1'b1);
    else owe(cp, 1'b1, 1'b0);
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (pend == 2'd0) begin
      if (!b[7]) begin
        owe(PointW'(b), 1'b1, 1'b0);
      end else if ((b & 8'hE0) == Lead2) begin
        acc = PointW'(b[4:0]) << 6;
        pend = 2'd1;
      end else if ((b & 8'hF0) == Lead3) begin
        acc = PointW'(b[3:0]) << 12;
        pend = 2'd2;
      end else if ((b & 8'hF8) == Lead4) begin
        acc = PointW'(b[2:0]) << 18;
        pend = 2'd3;
      end else begin
        owe('0, 1'b1, 1'b1);
      end
    end else begin
      pend = pend - 2'd1;
      acc = acc | (PointW'(b[5:0]) << (6 * pend));
      if (pend == 2'd0) owe_point(acc);
    end
  endtask

  task automatic take_unit16(input logic [15:0] u);
    if (pend == 2'd0) begin
      if ((u & SurrogateMask) == HighSurrogate) begin
        acc = PointW'(u[9:0]) << 10;
        pend = 2'd1;
      end else begin
        owe(PointW'(u), 1'b1, 1'b0);
      end
    end else begin
      pend = 2'd0;
      acc = ((acc & 21'h0FFC00) | PointW'(u[9:0])) + PlaneBase;
      owe_point(acc);
    end
  endtask

  task automatic emit_utf8(input logic [PointW-1:0] cp);
    if (cp <= MaxAscii) begin
      owe(cp, 1'b1, 1'b0);
    end else if (cp <= MaxTwoByte) begin
      owe(PointW'(Lead2 | {3'b0, cp[10:6]}), 1'b0, 1'b0);
      owe(PointW'(ContByte | {2'b0, cp[5:0]}), 1'b1, 1'b0);
    end else if (cp <= MaxBmp) begin
      owe(PointW'(Lead3 | {4'b0, cp[15:12]}), 1'b0, 1'b0);
      owe(PointW'(ContByte | {2'b0, cp[11:6]}), 1'b0, 1'b0);
      owe(PointW'(ContByte | {2'b0, cp[5:0]}), 1'b1, 1'b0);
    end else if (cp <= MaxPoint) begin
      owe(PointW'(Lead4 | {5'b0, cp[20:18]}), 1'b0, 1'b0);
      owe(PointW'(ContByte | {2'b0, cp[17:12]}), 1'b0, 1'b0);
      owe(PointW'(ContByte | {2'b0, cp[11:6]}), 1'b0, 1'b0);
      owe(PointW'(ContByte | {2'b0, cp[5:0]}), 1'b1, 1'b0);
    end else begin
      owe('0, 1'b1, 1'b1);
    end
  endtask

  task automatic emit_utf16(input logic [PointW-1:0] cp);
    logic [PointW-1:0] off;
    if (cp <= MaxBmp) begin
      owe(cp, 1'b1, 1'b0);
    end else if (cp <= MaxPoint) begin
      off = cp - PlaneBase;
      owe(PointW'(HighSurrogate | {6'b0, off[19:10]}), 1'b0, 1'b0);
      owe(PointW'(LowSurrogate | {6'b0, off[9:0]}), 1'b1, 1'b0);
    end else begin
      owe('0, 1'b1, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    unit_beat_t got;
    unit_beat_t want;
    if (rst) begin
      owed_q.delete();
      utf16 = 1'b0;
      encode_dir = 1'b0;
      pend = 2'd0;
      acc = '0;
      fails = 0;
      units = 0;
      beats = 0;
      errs = 0;
      writes = 0;
    end else begin
      if (result.valid && result.ready) begin
        beats++;
        got = '{result.out_value, result.last, result.error};
        if (got.error) errs++;
        if (owed_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result beat: value %h last %b error %b",
                     got.value, got.last, got.error);
        end else begin
          want = owed_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: got value %h last %b error %b, expected value %h last %b error %b",
                       got.value, got.last, got.error, want.value, want.last, want.error);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        writes++;
        case (cfg.index)
          CfgEncoding: begin
            utf16 = cfg.data;
            pend = 2'd0;
            acc = '0;
          end
          CfgDirection: begin
            encode_dir = cfg.data;
            pend = 2'd0;
            acc = '0;
          end
          default: ;
        endcase
      end
      if (feed.valid && feed.ready) begin
        units++;
        case ({encode_dir, utf16})
          2'b00: take_byte(feed.unit_value[7:0]);
          2'b01: take_unit16(feed.unit_value[15:0]);
          2'b10: emit_utf8(feed.unit_value);
          default: emit_utf16(feed.unit_value);
        endcase
      end
    end
    fail_count  <= fails;
    owed_count  <= owed_q.size();
    units_seen  <= units;
    beats_seen  <= beats;
    errors_seen <= errs;
    writes_seen <= writes;
  end

endmodule

// File: sim/unicode_transcoder_test.sv
// ----------------------------------------------------------------------------
// unicode_transcoder_test
// Testbench top of the unicode transcoder. Runs a directed pass over the
// boundary code points, bad lead bytes, surrogate pairs and partial
// sequences cut off by register writes, then random well-formed sequences
// mixed with noise in every encoding and direction, with random gaps on the
// feed side and random stalls on the result side in all but the last phase.
// ----------------------------------------------------------------------------
module unicode_transcoder_test;
  import utc_pkg::*;

  localparam int WatchLimit    = 2000;
  localparam int UnitsPerPhase = 56;

  localparam logic [CfgIdxW-1:0] CfgUnused2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnused3 = 2'd3;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic idle_on  = 1'b1;
  logic stall_on = 1'b1;
  int   quiet_cycles = 0;
  int   sent = 0;
  int   fail_count;
  int   owed_count;
  int   units_seen;
  int   beats_seen;
  int   errors_seen;
  int   writes_seen;

  utc_in_if  feed_ch ();
  utc_cfg_if cfg_ch ();
  utc_out_if res_ch ();

  unicode_transcoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  utc_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .feed        (feed_ch),
    .cfg         (cfg_ch),
    .result      (res_ch),
    .fail_count  (fail_count),
    .owed_count  (owed_count),
    .units_seen  (units_seen),
    .beats_seen  (beats_seen),
    .errors_seen (errors_seen),
    .writes_seen (writes_seen)
  );

  always #4 clk = ~clk;

  // result side stalls
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (feed_ch.valid && feed_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("timeout: no beat moved for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [PointW-1:0] pad_unit(input logic [15:0] low, input logic wide);
    logic [PointW-1:0] hi;
    hi = PointW'($urandom) & (wide ? 21'h1F0000 : 21'h1FFF00);
    return ($urandom_range(0, 3) == 0) ? (PointW'(low) | hi) : PointW'(low);
  endfunction

  task automatic send_unit(input logic [PointW-1:0] v);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      feed_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed_ch.valid <= 1'b1;
    feed_ch.unit_value <= v;
    @(posedge clk);
    while (!feed_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
    feed_ch.valid <= 1'b0;
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random(input logic utf16, input logic encode_dir);
    int pick;
    int len;
    logic [7:0] b;
    logic [15:0] u;
    logic [PointW-1:0] cp;
    pick = $urandom_range(0, 9);
    if (encode_dir) begin
      case (pick)
        0: cp = PointW'($urandom_range(0, 'h7F));
        1: cp = PointW'($urandom_range('h80, 'h7FF));
        2, 3: cp = PointW'($urandom_range('h800, 'hFFFF));
        4, 5: cp = PointW'($urandom_range('h10000, 'h10FFFF));
        6: cp = PointW'($urandom_range('h110000, 'h1FFFFF));
        7: cp = PointW'($urandom);
        default: begin
          case ($urandom_range(0, 9))
            0: cp = '0;
            1: cp = MaxAscii;
            2: cp = MaxAscii + 21'd1;
            3: cp = MaxTwoByte;
            4: cp = MaxTwoByte + 21'd1;
            5: cp = MaxBmp;
            6: cp = PlaneBase;
            7: cp = MaxPoint;
            8: cp = MaxPoint + 21'd1;
            default: cp = '1;
          endcase
        end
      endcase
      send_unit(cp);
    end else if (!utf16) begin
      if (pick < 7) begin
        len = $urandom_range(1, 4);
        b = 8'($urandom);
        case (len)
          1: b[7] = 1'b0;
          2: b[7:5] = 3'b110;
          3: b[7:4] = 4'b1110;
          default: b[7:3] = 5'b11110;
        endcase
        send_unit(pad_unit({8'h00, b}, 1'b0));
        for (int i = 1; i < len; i++) begin
          b = 8'($urandom);
          if ($urandom_range(0, 7) != 0) b[7:6] = 2'b10;
          send_unit(pad_unit({8'h00, b}, 1'b0));
        end
      end else begin
        send_unit(pad_unit({8'h00, 8'($urandom)}, 1'b0));
      end
    end else begin
      if (pick < 4) begin
        send_unit(pad_unit(16'($urandom), 1'b1));
      end else if (pick < 8) begin
        u = {6'b110110, 10'($urandom)};
        send_unit(pad_unit(u, 1'b1));
        u = {6'b110111, 10'($urandom)};
        if ($urandom_range(0, 7) == 0) u = 16'($urandom);
        send_unit(pad_unit(u, 1'b1));
      end else begin
        send_unit(pad_unit(16'($urandom), 1'b1));
      end
    end
  endtask

  initial begin
    logic [PointW-1:0] dec8_seq [12];
    logic [PointW-1:0] enc8_seq [4];
    logic [PointW-1:0] enc16_seq [4];
    int target;
    dec8_seq = '{21'h1FFF7F, 21'h0000C2, 21'h1FFFA9, 21'h0000F4,
                 21'h00008F, 21'h0000BF, 21'h0000BF, 21'h0000F5,
                 21'h000080, 21'h000080, 21'h000080, 21'h0000FF};
    enc8_seq  = '{21'h0007FF, 21'h000800, 21'h10FFFF, 21'h1FFFFF};
    enc16_seq = '{21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h110000};
    feed_ch.valid <= 1'b0;
    feed_ch.unit_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CfgEncoding;
    cfg_ch.data <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // utf-8 decode after reset: junk high bits, max point, too-large lead, bad lead
    foreach (dec8_seq[i]) send_unit(dec8_seq[i]);
    write_reg(CfgDirection, 1'b1);
    foreach (enc8_seq[i]) send_unit(enc8_seq[i]);

    write_reg(CfgEncoding, 1'b1);
    write_reg(CfgDirection, 1'b0);
    send_unit(21'h1FFFFF);
    send_unit(21'h00DBFF);
    send_unit(21'h00DFFF);
    send_unit(21'h00DC00);
    // unused index must leave the pending high half alone
    send_unit(21'h00D800);
    write_reg(CfgUnused3, 1'b1);
    send_unit(21'h00DC01);
    // real write drops the pending high half
    send_unit(21'h00D800);
    write_reg(CfgEncoding, 1'b1);
    send_unit(21'h00DC00);
    write_reg(CfgDirection, 1'b1);
    foreach (enc16_seq[i]) send_unit(enc16_seq[i]);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        idle_on <= 1'b0;
        stall_on <= 1'b0;
      end
      if ($urandom_range(0, 1) == 1)
        write_reg(($urandom_range(0, 1) == 1) ? CfgUnused2 : CfgUnused3, 1'($urandom));
      write_reg(CfgEncoding, ph[0]);
      write_reg(CfgDirection, ph[1]);
      target = sent + UnitsPerPhase;
      while (sent < target) send_random(ph[0], ph[1]);
    end

    feed_ch.valid <= 1'b0;
    settle();
    $display("covered %0d feed beats, %0d result beats (%0d with error), %0d register writes",
             units_seen, beats_seen, errors_seen, writes_seen);
    $display("both encodings in both directions, twice each in the random part");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: unicode_transcoder.f
hdl/utc_pkg.sv
hdl/utc_in_if.sv
hdl/utc_out_if.sv
hdl/utc_cfg_if.sv
hdl/utc_front.sv
hdl/utc_queue.sv
hdl/utc_back.sv
hdl/unicode_transcoder.sv
sim/utc_checker.sv
sim/unicode_transcoder_test.sv
